// ===== rtl/core/kmp_pkg.sv =====
// Package for the KMP pattern matcher: command codes, field widths and defaults.
// Used by kmp_pattern_matcher_top; depends on nothing else.
package kmp_pkg;

  localparam int CMD_W      = 2;
  localparam int SYMBOL_W   = 8;
  localparam int COUNT_W    = 32;
  localparam int MAX_PATTERN_DEF = 256;

  // command codes of the input channel
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

endpackage

// ===== rtl/core/kmp_ram.sv =====
// Simple dual-port memory: one write port, one read port, registered read data.
// Depends on no package; instantiated by kmp_pattern_matcher_top.
module kmp_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/kmp_pattern_matcher_top.sv =====
// KMP pattern matcher top level: sequencer, working registers and output register.
// Depends on kmp_pkg; instantiates kmp_ram for the pattern store and failure table.
//
//  channel | ports                                          | handshake
//  --------+------------------------------------------------+--------------
//  in      | in_command, in_symbol, in_last_symbol          | in_valid/in_ready
//  out     | out_found, out_match_start, out_not_found,     | out_valid/out_ready
//          | out_comparison_total, out_pattern_overflow     |
//
// Every request gives one result. A restart, a full-store or first-byte load, or an
// empty-pattern or finished-search text byte goes from accept straight to emit. Text
// takes one compare step per comparison, a miss at a nonzero index following a failure
// link; a load takes one build step per prefix probe, each one read of both memories.
// Reset (rst_n low, synchronous) clears the control state; the memories are not cleared.
// A new request is taken while the previous result waits in the output register; a
// stalled output holds the sequencer in its emit step until the result slot frees.
module kmp_pattern_matcher_top #(
  parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kmp_pkg::CMD_W-1:0]     in_command,
  input  logic [kmp_pkg::SYMBOL_W-1:0]  in_symbol,
  input  logic                          in_last_symbol,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [kmp_pkg::COUNT_W-1:0]   out_match_start,
  output logic                          out_not_found,
  output logic [kmp_pkg::COUNT_W-1:0]   out_comparison_total,
  output logic                          out_pattern_overflow
);
  import kmp_pkg::*;

  localparam int IW = $clog2(MAX_PATTERN);
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam logic [LW-1:0]      LEN_FULL = LW'(MAX_PATTERN);
  localparam logic [COUNT_W-1:0] CNT_MAX  = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_BUILD,
    S_EMIT
  } state_t;

  state_t               state_r;
  logic [LW-1:0]        len_r;
  logic [IW-1:0]        build_r;
  logic [IW-1:0]        match_r;
  logic [IW-1:0]        idx_r;
  logic [COUNT_W-1:0]   pos_r;
  logic [COUNT_W-1:0]   cnt_r;
  logic                 done_r;
  logic [SYMBOL_W-1:0]  sym_r;
  logic                 last_r;
  logic                 res_found_r;
  logic [COUNT_W-1:0]   res_start_r;
  logic                 res_nf_r;
  logic                 res_ovf_r;
  logic                 out_valid_r;
  logic                 out_found_r;
  logic [COUNT_W-1:0]   out_start_r;
  logic                 out_nf_r;
  logic [COUNT_W-1:0]   out_cnt_r;
  logic                 out_ovf_r;

  logic                 accept;
  logic [IW-1:0]        rd_idx;
  logic [IW-1:0]        fail_raddr;
  logic [SYMBOL_W-1:0]  pat_rd;
  logic [IW-1:0]        fail_rd;
  logic                 sym_hit;
  logic                 build_end;
  logic [IW-1:0]        knew;
  logic                 first_load;
  logic                 mem_we;
  logic [SYMBOL_W-1:0]  pat_wdata;
  logic [IW-1:0]        fail_wdata;
  logic [COUNT_W-1:0]   cnt_inc;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // probe address: the entry point on accept, else the failure link just read
  always_comb begin
    if (state_r == S_IDLE) begin
      rd_idx = (in_command == CMD_LOAD) ? build_r : match_r;
    end else begin
      rd_idx = fail_rd;
    end
    fail_raddr = (rd_idx == '0) ? '0 : rd_idx - IW'(1);
  end

  assign sym_hit   = (pat_rd == sym_r);
  assign build_end = (idx_r == '0) || sym_hit;
  assign knew      = sym_hit ? idx_r + IW'(1) : idx_r;

  // write back the new pattern byte and its failure link; first byte writes from idle.
  // Writes land at the end of an item, reads start a later item, so no overlap arises.
  assign first_load = accept && (in_command == CMD_LOAD) && (len_r == '0);
  assign mem_we     = first_load || (state_r == S_BUILD && build_end);
  assign pat_wdata  = (state_r == S_IDLE) ? in_symbol : sym_r;
  assign fail_wdata = (state_r == S_IDLE) ? '0 : knew;

  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + COUNT_W'(1);

  kmp_ram #(
    .DEPTH (MAX_PATTERN),
    .WIDTH (SYMBOL_W)
  ) u_pattern (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (len_r[IW-1:0]),
    .wr_data (pat_wdata),
    .rd_addr (rd_idx),
    .rd_data (pat_rd)
  );

  kmp_ram #(
    .DEPTH (MAX_PATTERN),
    .WIDTH (IW)
  ) u_failure (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (len_r[IW-1:0]),
    .wr_data (fail_wdata),
    .rd_addr (fail_raddr),
    .rd_data (fail_rd)
  );

  // sequencer, search state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      build_r     <= '0;
      match_r     <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once taken; the emit step handles its own slot
      if (out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            sym_r       <= in_symbol;
            last_r      <= in_last_symbol;
            res_found_r <= 1'b0;
            res_start_r <= '0;
            res_nf_r    <= 1'b0;
            res_ovf_r   <= (in_command == CMD_LOAD) && (len_r == LEN_FULL);
            unique case (in_command)
              CMD_LOAD: begin
                match_r <= '0;
                pos_r   <= '0;
                done_r  <= 1'b0;
                if (len_r == LEN_FULL) begin
                  state_r <= S_EMIT;
                end else if (len_r == '0) begin
                  build_r <= '0;
                  len_r   <= LW'(1);
                  state_r <= S_EMIT;
                end else begin
                  idx_r   <= build_r;
                  state_r <= S_BUILD;
                end
              end
              CMD_TEXT: begin
                if (len_r != '0 && !done_r) begin
                  idx_r   <= match_r;
                  state_r <= S_CMP;
                end else begin
                  state_r <= S_EMIT;
                end
              end
              CMD_RESTART: begin
                match_r <= '0;
                pos_r   <= '0;
                done_r  <= 1'b0;
                state_r <= S_EMIT;
              end
              default: begin
                state_r <= S_EMIT;
              end
            endcase
          end
        end
        S_CMP: begin
          cnt_r <= cnt_inc;
          if (sym_hit) begin
            if (LW'(idx_r) == len_r - LW'(1)) begin
              res_found_r <= 1'b1;
              res_start_r <= pos_r - (COUNT_W'(len_r) - COUNT_W'(1));
              done_r      <= 1'b1;
              match_r     <= '0;
            end else begin
              match_r <= idx_r + IW'(1);
              pos_r   <= pos_r + COUNT_W'(1);
              if (last_r) begin
                res_nf_r <= 1'b1;
                done_r   <= 1'b1;
              end
            end
            state_r <= S_EMIT;
          end else if (idx_r != '0) begin
            // follow the failure link and compare again
            idx_r <= fail_rd;
          end else begin
            match_r <= '0;
            pos_r   <= pos_r + COUNT_W'(1);
            if (last_r) begin
              res_nf_r <= 1'b1;
              done_r   <= 1'b1;
            end
            state_r <= S_EMIT;
          end
        end
        S_BUILD: begin
          if (build_end) begin
            build_r <= knew;
            len_r   <= len_r + LW'(1);
            state_r <= S_EMIT;
          end else begin
            idx_r <= fail_rd;
          end
        end
        S_EMIT: begin
          // hold until the output slot is free
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_found_r <= res_found_r;
            out_start_r <= res_start_r;
            out_nf_r    <= res_nf_r;
            out_cnt_r   <= cnt_r;
            out_ovf_r   <= res_ovf_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_found            = out_found_r;
  assign out_match_start      = out_start_r;
  assign out_not_found        = out_nf_r;
  assign out_comparison_total = out_cnt_r;
  assign out_pattern_overflow = out_ovf_r;

endmodule
